// ----- design/cuc_pkg.sv -----
package cuc_pkg;

   // request codes
   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_DECODE = 1'b1;

   // result codes
   localparam logic KIND_BYTE  = 1'b0;
   localparam logic KIND_VALUE = 1'b1;

   // form constants
   localparam int unsigned MAX_BYTES = 9;
   localparam logic [7:0]  WIDE_TYPE_BYTE = 8'h80;
   localparam logic [3:0]  WIDE_LENGTH = 4'd9;

   typedef struct packed {
      logic        req_type;
      logic [63:0] value_in;
      logic [7:0]  byte_in;
   } req_payload_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  out_byte;
      logic        last;
      logic [63:0] decoded_value;
      logic [3:0]  coded_length;
   } rsp_payload_type;

   // encoded form of one value, byte 0 first
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [3:0]                length;
   } enc_form_type;

   // decoder answer for one byte
   typedef struct packed {
      logic        valid;
      logic [63:0] value;
      logic [3:0]  length;
   } dec_result_type;

endpackage

// ----- design/cuc_encoder.sv -----
module cuc_encoder (
   input  logic [63:0]          value_in,
   output cuc_pkg::enc_form_type form
);
   import cuc_pkg::*;

   logic [3:0]  len;
   logic [7:0]  type_byte;
   logic [63:0] rest;

   // shortest form that holds the value
   always_comb begin
      priority if (value_in[63:7] == '0) begin
         len = 4'd1;
      end else if (value_in[63:14] == '0) begin
         len = 4'd2;
      end else if (value_in[63:21] == '0) begin
         len = 4'd3;
      end else if (value_in[63:28] == '0) begin
         len = 4'd4;
      end else if (value_in[63:35] == '0) begin
         len = 4'd5;
      end else if (value_in[63:42] == '0) begin
         len = 4'd6;
      end else if (value_in[63:49] == '0) begin
         len = 4'd7;
      end else begin
         len = WIDE_LENGTH;
      end
   end

   // type byte and the bytes that follow it
   always_comb begin
      priority if (value_in == '0) begin
         type_byte = 8'h00;
         rest      = '0;
      end else if (len == WIDE_LENGTH) begin
         type_byte = WIDE_TYPE_BYTE;
         rest      = value_in;
      end else begin
         type_byte = 8'(value_in[7:0] << len) | 8'(8'd1 << (len - 4'd1));
         rest      = value_in >> (4'd8 - len);
      end
   end

   // pack the byte lanes
   always_comb begin
      form.length   = len;
      form.bytes[0] = type_byte;
      for (int i = 1; i < MAX_BYTES; i++) begin
         form.bytes[i] = rest[8*(i-1) +: 8];
      end
   end

endmodule

// ----- design/cuc_decoder.sv -----
module cuc_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic [7:0]             byte_in,
   output cuc_pkg::dec_result_type result
);
   import cuc_pkg::*;

   logic [3:0]  bytes_left_ff, bytes_left_in;
   logic [3:0]  total_length_ff, total_length_in;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  bit_pos_ff, bit_pos_in;
   logic [2:0]  low_bit;
   logic [63:0] acc_merged;

   // position of the lowest set bit of the type byte
   always_comb begin
      low_bit = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (byte_in[i]) begin
            low_bit = 3'(i);
         end
      end
   end

   assign acc_merged = acc_ff | (64'(byte_in) << bit_pos_ff[5:0]);

   // state update and result for one byte
   always_comb begin
      bytes_left_in   = bytes_left_ff;
      total_length_in = total_length_ff;
      acc_in          = acc_ff;
      bit_pos_in      = bit_pos_ff;
      result.valid    = 1'b0;
      result.value    = acc_ff;
      result.length   = total_length_ff;
      if (fire) begin
         if (bytes_left_ff == '0) begin
            if (byte_in == 8'h00) begin
               result.valid  = 1'b1;
               result.value  = '0;
               result.length = 4'd1;
            end else if (low_bit == 3'd7) begin
               total_length_in = WIDE_LENGTH;
               acc_in          = '0;
               bit_pos_in      = '0;
               bytes_left_in   = WIDE_LENGTH - 4'd1;
            end else begin
               total_length_in = 4'(low_bit) + 4'd1;
               acc_in          = 64'(byte_in >> (4'(low_bit) + 4'd1));
               bit_pos_in      = 7'd7 - 7'(low_bit);
               bytes_left_in   = 4'(low_bit);
               if (low_bit == 3'd0) begin
                  result.valid  = 1'b1;
                  result.value  = 64'(byte_in >> 1);
                  result.length = 4'd1;
               end
            end
         end else begin
            acc_in        = acc_merged;
            bit_pos_in    = bit_pos_ff + 7'd8;
            bytes_left_in = bytes_left_ff - 4'd1;
            if (bytes_left_ff == 4'd1) begin
               result.valid  = 1'b1;
               result.value  = acc_merged;
               result.length = total_length_ff;
            end
         end
      end
   end

   // decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff   <= '0;
         total_length_ff <= '0;
         acc_ff          <= '0;
         bit_pos_ff      <= '0;
      end else begin
         bytes_left_ff   <= bytes_left_in;
         total_length_ff <= total_length_in;
         acc_ff          <= acc_in;
         bit_pos_ff      <= bit_pos_in;
      end
   end

endmodule

// ----- design/compact_uint64_codec_top.sv -----
// compact varint codec, 64-bit unsigned values
//
// req channel: req_valid / req_stall / req_payload. req_type selects an
// encode of value_in or a decode of one byte_in of an encoded stream.
// rsp channel: rsp_valid / rsp_stall / rsp_payload. An encode gives 1 to 9
// byte results (last set on the final one); a decode byte gives a value
// result once its form is complete, otherwise nothing.
//
// requests are held in the work register, results in the result register.
// throughput: while the receiver does not stall, decode takes one byte
// per cycle, and an encode holds the byte serialiser until its bytes
// (1..7 or 9) are out, one byte out per cycle. The next request is taken
// in the cycle its predecessor's last byte moves into the result register.
//
// a stalled receiver holds the result register, and with it the request
// side. Reset clears the decode state (waiting for a type byte) and empties
// the pipeline. An encode between bytes of a decode leaves it untouched.
module compact_uint64_codec_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cuc_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cuc_pkg::rsp_payload_type rsp_payload
);
   import cuc_pkg::*;

   enc_form_type    enc_form;
   dec_result_type  dec_result;

   logic            work_valid_ff, work_valid_in;
   logic            work_kind_ff;
   enc_form_type    work_form_ff;
   logic [7:0]      work_byte_ff;
   logic [3:0]      work_idx_ff, work_idx_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            req_fire;
   logic            out_free;
   logic            step;
   logic            enc_last;
   logic            work_done;
   logic            dec_fire;

   // form builder on the incoming value
   cuc_encoder u_encoder (
      .value_in (req_payload.value_in),
      .form     (enc_form)
   );

   // byte-at-a-time decoder
   cuc_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .fire    (dec_fire),
      .byte_in (work_byte_ff),
      .result  (dec_result)
   );

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = work_valid_ff && out_free;
   assign enc_last  = work_idx_ff == (work_form_ff.length - 4'd1);
   assign work_done = step && ((work_kind_ff == REQ_DECODE) || enc_last);
   assign dec_fire  = step && (work_kind_ff == REQ_DECODE);
   assign req_stall = work_valid_ff && !work_done;
   assign req_fire  = req_valid && !req_stall;

   // work register next state
   always_comb begin
      work_valid_in = work_valid_ff;
      work_idx_in   = work_idx_ff;
      if (req_fire) begin
         work_valid_in = 1'b1;
         work_idx_in   = '0;
      end else if (work_done) begin
         work_valid_in = 1'b0;
      end else if (step) begin
         work_idx_in = work_idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         work_idx_ff   <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         work_idx_ff   <= work_idx_in;
      end
   end

   // request payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         work_kind_ff <= req_payload.req_type;
         work_form_ff <= enc_form;
         work_byte_ff <= req_payload.byte_in;
      end
   end

   // result selection
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (step && (work_kind_ff == REQ_ENCODE)) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.result_kind   = KIND_BYTE;
         rsp_payload_in.out_byte      = work_form_ff.bytes[work_idx_ff];
         rsp_payload_in.last          = enc_last;
         rsp_payload_in.decoded_value = '0;
         rsp_payload_in.coded_length  = work_form_ff.length;
      end else if (step && dec_result.valid) begin
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.result_kind   = KIND_VALUE;
         rsp_payload_in.out_byte      = '0;
         rsp_payload_in.last          = 1'b0;
         rsp_payload_in.decoded_value = dec_result.value;
         rsp_payload_in.coded_length  = dec_result.length;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// ----- tb/cuc_checker.sv -----
`timescale 1ns / 100ps

// watches both channels, predicts the codec's results and compares them
module cuc_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  cuc_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  cuc_pkg::rsp_payload_type rsp_payload,
   output int unsigned              fail_count,
   output int unsigned              pending_count
);

   import cuc_pkg::*;

   // decoder state as the block should hold it
   logic [3:0]  dec_left;
   logic [3:0]  dec_len;
   logic [63:0] dec_acc;
   logic [6:0]  dec_shift;

   // results still owed by the block, oldest first
   rsp_payload_type owed_results[$];

   rsp_payload_type want;
   rsp_payload_type got;
   logic            differs;

   function automatic rsp_payload_type byte_result(input logic [7:0] b, input logic is_last,
                                                   input logic [3:0] len);
      rsp_payload_type r;
      r.result_kind   = KIND_BYTE;
      r.out_byte      = b;
      r.last          = is_last;
      r.decoded_value = '0;
      r.coded_length  = len;
      return r;
   endfunction

   function automatic rsp_payload_type value_result(input logic [63:0] v,
                                                    input logic [3:0] len);
      rsp_payload_type r;
      r.result_kind   = KIND_VALUE;
      r.out_byte      = '0;
      r.last          = 1'b0;
      r.decoded_value = v;
      r.coded_length  = len;
      return r;
   endfunction

   // shortest form that holds the value, bytes queued in order
   task automatic queue_encoding(input logic [63:0] v);
      int unsigned n;
      int unsigned i;
      logic [63:0] rest;
      logic [7:0]  lead;
      if (v == 64'd0) begin
         owed_results.push_back(byte_result(8'h00, 1'b1, 4'd1));
      end else begin
         n = 1;
         while (n <= 7 && v >= (64'd1 << (7 * n))) n++;
         if (n <= 7) begin
            // marker bit at n-1, low value bits above it
            lead = 8'((64'd1 << (n - 1)) | ((v & ((64'd1 << (8 - n)) - 64'd1)) << n));
            rest = v >> (8 - n);
            owed_results.push_back(byte_result(lead, n == 1, 4'(n)));
            for (i = 1; i < n; i++) begin
               owed_results.push_back(byte_result(rest[7:0], i == n - 1, 4'(n)));
               rest = rest >> 8;
            end
         end else begin
            // wide form: type byte then the value little-endian
            rest = v;
            owed_results.push_back(byte_result(WIDE_TYPE_BYTE, 1'b0, WIDE_LENGTH));
            for (i = 1; i < 9; i++) begin
               owed_results.push_back(byte_result(rest[7:0], i == 8, WIDE_LENGTH));
               rest = rest >> 8;
            end
         end
      end
   endtask

   // one decode byte into the form being collected
   task automatic absorb_byte(input logic [7:0] b);
      int unsigned p;
      if (dec_left == 4'd0) begin
         if (b == 8'h00) begin
            owed_results.push_back(value_result(64'd0, 4'd1));
         end else begin
            p = 0;
            while (!b[p]) p++;
            if (p == 7) begin
               dec_len   = WIDE_LENGTH;
               dec_acc   = '0;
               dec_shift = '0;
            end else begin
               dec_len   = 4'(p + 1);
               dec_acc   = {56'd0, b} >> (p + 1);
               dec_shift = 7'(7 - p);
            end
            dec_left = dec_len - 4'd1;
            if (dec_left == 4'd0) owed_results.push_back(value_result(dec_acc, dec_len));
         end
      end else begin
         dec_acc   = dec_acc | ({56'd0, b} << dec_shift[5:0]);
         dec_shift = dec_shift + 7'd8;
         dec_left  = dec_left - 4'd1;
         if (dec_left == 4'd0) owed_results.push_back(value_result(dec_acc, dec_len));
      end
   endtask

   // prediction on request transfers, comparison on result transfers
   always @(posedge clock) begin
      if (reset) begin
         owed_results.delete();
         dec_left      = '0;
         dec_len       = '0;
         dec_acc       = '0;
         dec_shift     = '0;
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_payload.req_type == REQ_ENCODE) queue_encoding(req_payload.value_in);
            else absorb_byte(req_payload.byte_in);
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            if (owed_results.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result: expected none",
                        $time);
               $display("%0t   actual kind %0d byte %02h last %0d value %016h len %0d",
                        $time, got.result_kind, got.out_byte, got.last,
                        got.decoded_value, got.coded_length);
            end else begin
               want    = owed_results.pop_front();
               differs = (got.result_kind !== want.result_kind) ||
                         (got.out_byte !== want.out_byte) ||
                         (got.last !== want.last) ||
                         (got.decoded_value !== want.decoded_value) ||
                         (got.coded_length !== want.coded_length);
               if (differs) begin
                  fail_count++;
                  $display("%0t mismatch: expected kind %0d byte %02h last %0d",
                           $time, want.result_kind, want.out_byte, want.last);
                  $display("%0t   expected value %016h len %0d",
                           $time, want.decoded_value, want.coded_length);
                  $display("%0t   actual kind %0d byte %02h last %0d",
                           $time, got.result_kind, got.out_byte, got.last);
                  $display("%0t   actual value %016h len %0d",
                           $time, got.decoded_value, got.coded_length);
               end
            end
         end
         pending_count = owed_results.size();
      end
   end

endmodule

// ----- tb/tb_compact_uint64_codec_top.sv -----
`timescale 1ns / 100ps

module tb_compact_uint64_codec_top;

   import cuc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned RANDOM_ITEMS = 210;
   localparam int unsigned HOLD_CYCLES  = 90;
   localparam int unsigned TAIL_CYCLES  = 20;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   int unsigned fail_count;
   int unsigned pending_count;

   // sender pacing
   int unsigned burst_left;
   int unsigned rush_left;
   int unsigned sent_items;
   logic        hold_request;
   logic        hold_done;
   logic        pause_done;

   // receiver pattern
   stall_mode_type stall_mode;
   int unsigned phase_left;
   int unsigned hold_left;
   int unsigned cycle_count;

   compact_uint64_codec_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   cuc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // encode request, unused byte field filled with noise
   function automatic req_payload_type encode_req(input logic [63:0] v);
      req_payload_type r;
      r.req_type = REQ_ENCODE;
      r.value_in = v;
      r.byte_in  = 8'($urandom);
      return r;
   endfunction

   // decode request, unused value field filled with noise
   function automatic req_payload_type decode_req(input logic [7:0] b);
      req_payload_type r;
      r.req_type = REQ_DECODE;
      r.value_in = {$urandom, $urandom};
      r.byte_in  = b;
      return r;
   endfunction

   // random value of random bit length, so every form length comes up
   function automatic logic [63:0] random_value();
      int unsigned w;
      logic [63:0] v;
      w = $urandom_range(0, 64);
      v = {$urandom, $urandom};
      if (w < 64) v = v & ((64'd1 << w) - 64'd1);
      return v;
   endfunction

   // one request transfer, with random gaps between bursts
   task automatic offer_request(input req_payload_type item);
      int unsigned gap;
      if (burst_left == 0 && rush_left == 0) begin
         gap = $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left != 0) burst_left--;
      if (rush_left != 0) rush_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   // sender stops until every owed result has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // random form: zero byte, or type byte with marker at a random position, then its bytes
   task automatic offer_random_form();
      int unsigned p;
      int unsigned len;
      int unsigned k;
      logic [7:0]  lead;
      p = $urandom_range(0, 7);
      if ($urandom_range(0, 11) == 0) begin
         lead = 8'h00;
         len  = 1;
      end else if (p == 7) begin
         lead = WIDE_TYPE_BYTE;
         len  = 9;
      end else begin
         lead = (8'($urandom) << (p + 1)) | (8'd1 << p);
         len  = p + 1;
      end
      offer_request(decode_req(lead));
      for (k = 1; k < len; k++) begin
         // an encode between the bytes must leave the decode alone
         if ($urandom_range(0, 5) == 0) offer_request(encode_req(random_value()));
         offer_request(decode_req(8'($urandom)));
      end
   endtask

   // receiver: changing stall pattern, plus one long hold-off on request
   initial begin
      rsp_stall  = 1'b0;
      hold_left  = 0;
      phase_left = 0;
      stall_mode = STALL_NONE;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (phase_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            unique case (stall_mode)
               STALL_NONE: begin
                  rsp_stall <= 1'b0;
               end
               STALL_LIGHT: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               STALL_HEAVY: begin
                  rsp_stall <= ($urandom_range(0, 9) < 7);
               end
               STALL_PERIODIC: begin
                  rsp_stall <= ((phase_left % 5) < 2);
               end
            endcase
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("compact_uint64_codec_top verification failed");
      $finish;
   end

   // stimulus and verdict
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      burst_left   = 0;
      rush_left    = 0;
      sent_items   = 0;
      hold_request = 1'b0;
      hold_done    = 1'b0;
      pause_done   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // encode at the 1/2, 2/3 and 7/9-byte form boundaries and the extremes
      offer_request(encode_req(64'd0));
      offer_request(encode_req(64'd1));
      offer_request(encode_req(64'd127));
      offer_request(encode_req(64'd128));
      offer_request(encode_req(64'd16384));
      offer_request(encode_req(64'h0001_FFFF_FFFF_FFFF));
      offer_request(encode_req(64'h0002_0000_0000_0000));
      offer_request(encode_req(64'hFFFF_FFFF_FFFF_FFFF));
      // zero type byte, and a full one-byte form
      offer_request(decode_req(8'h00));
      offer_request(decode_req(8'hFF));
      // wide form of all ones
      offer_request(decode_req(WIDE_TYPE_BYTE));
      repeat (8) offer_request(decode_req(8'hFF));
      // three-byte form with an encode in the middle
      offer_request(decode_req(8'hFC));
      offer_request(encode_req(64'd12345));
      offer_request(decode_req(8'hA5));
      offer_request(decode_req(8'h5A));
      // longer form than needed for the value one
      offer_request(decode_req(8'h06));
      offer_request(decode_req(8'h00));
      drain_results();

      // random mix: mostly whole forms and encodes, some stray bytes
      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         if (!hold_done && sent_items >= 60) begin
            hold_done    = 1'b1;
            hold_request = 1'b1;
            rush_left    = 40;
         end
         if (!pause_done && sent_items >= 140) begin
            pause_done = 1'b1;
            drain_results();
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: offer_request(encode_req(random_value()));
            9: begin
               if ($urandom_range(0, 1) == 0) offer_request(decode_req(8'($urandom)));
               else offer_request(encode_req({$urandom, $urandom}));
            end
            default: offer_random_form();
         endcase
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("compact_uint64_codec_top verification clean");
      end else begin
         $display("compact_uint64_codec_top verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/cuc_pkg.sv
design/cuc_encoder.sv
design/cuc_decoder.sv
design/compact_uint64_codec_top.sv
tb/cuc_checker.sv
tb/tb_compact_uint64_codec_top.sv
